// File: sv/lfd_pkg.sv
`timescale 1ns / 1ps

package lfd_pkg;

    localparam int MAX_HEADER_BYTES = 64;

    // header byte position and header size widths
    localparam int POS_W = $clog2(MAX_HEADER_BYTES);
    localparam int HDR_W = $clog2(MAX_HEADER_BYTES + 1);

    // register widths, fixed by the register map
    localparam int HB_W   = 7;
    localparam int OFS_W  = 6;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 3;

    // compare widths wide enough for both operands
    localparam int HCMP_W = (HDR_W > HB_W) ? HDR_W : HB_W;
    localparam int OCMP_W = (POS_W > OFS_W) ? POS_W : OFS_W;

    localparam int LEN_W  = 32;
    localparam int FLEN_W = 33;

    localparam logic [HB_W-1:0] HEADER_BYTES_RST = 7'd4;
    localparam logic [OFS_W-1:0] FIELD_OFFSET_RST = 6'd1;

    typedef enum logic [IDX_W-1:0] {
        CFG_HEADER_BYTES  = 3'd0,
        CFG_FIELD_OFFSET  = 3'd1,
        CFG_SIZE_CODE     = 3'd2,
        CFG_BIG_ENDIAN    = 3'd3,
        CFG_COUNTS_HEADER = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SIZE_1B   = 2'd0,
        SIZE_2B   = 2'd1,
        SIZE_4B   = 2'd2,
        SIZE_NONE = 2'd3
    } size_code_t;

    typedef struct packed {
        logic [HDR_W-1:0] hdr_len;       // effective header size, 1..MAX
        logic [OFS_W-1:0] field_ofs;
        size_code_t       size_code;
        logic             big_endian;
        logic             counts_header;
    } cfg_t;

    function automatic logic [2:0] field_size(input size_code_t code);
        logic [2:0] sz;
        sz = 3'd0;
        case (code)
            SIZE_1B: sz = 3'd1;
            SIZE_2B: sz = 3'd2;
            SIZE_4B: sz = 3'd4;
            default: sz = 3'd0;
        endcase
        return sz;
    endfunction

endpackage

// File: sv/lfd_cfg.sv
`timescale 1ns / 1ps

module lfd_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lfd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lfd_pkg::CFG_W-1:0]   cfg_wdata,
    output lfd_pkg::cfg_t               cfg
);

    logic [lfd_pkg::HB_W-1:0]   header_bytes_reg;
    logic [lfd_pkg::OFS_W-1:0]  field_ofs_reg;
    lfd_pkg::size_code_t        size_code_reg;
    logic                       big_endian_reg;
    logic                       counts_header_reg;

    logic [lfd_pkg::HCMP_W-1:0] hb_ext;
    logic [lfd_pkg::HCMP_W-1:0] hb_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_bytes_reg  <= lfd_pkg::HEADER_BYTES_RST;
            field_ofs_reg     <= lfd_pkg::FIELD_OFFSET_RST;
            size_code_reg     <= lfd_pkg::SIZE_2B;
            big_endian_reg    <= 1'b0;
            counts_header_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (lfd_pkg::cfg_idx_t'(cfg_index))
                lfd_pkg::CFG_HEADER_BYTES:  header_bytes_reg  <= cfg_wdata[lfd_pkg::HB_W-1:0];
                lfd_pkg::CFG_FIELD_OFFSET:  field_ofs_reg     <= cfg_wdata[lfd_pkg::OFS_W-1:0];
                lfd_pkg::CFG_SIZE_CODE:     size_code_reg     <= lfd_pkg::size_code_t'(cfg_wdata[1:0]);
                lfd_pkg::CFG_BIG_ENDIAN:    big_endian_reg    <= cfg_wdata[0];
                lfd_pkg::CFG_COUNTS_HEADER: counts_header_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // zero header acts as one byte, oversize saturates
    always_comb begin
        hb_ext = lfd_pkg::HCMP_W'(header_bytes_reg);
        if (hb_ext == '0) begin
            hb_sat = lfd_pkg::HCMP_W'(1);
        end else if (hb_ext > lfd_pkg::HCMP_W'(lfd_pkg::MAX_HEADER_BYTES)) begin
            hb_sat = lfd_pkg::HCMP_W'(lfd_pkg::MAX_HEADER_BYTES);
        end else begin
            hb_sat = hb_ext;
        end
    end

    assign cfg.hdr_len       = lfd_pkg::HDR_W'(hb_sat);
    assign cfg.field_ofs     = field_ofs_reg;
    assign cfg.size_code     = size_code_reg;
    assign cfg.big_endian    = big_endian_reg;
    assign cfg.counts_header = counts_header_reg;

endmodule

// File: sv/length_field_frame_deframer.sv
`timescale 1ns / 1ps
// Length-field frame deframer.
// Bytes enter on the s_ channel, one per transaction, and leave unchanged on
// the m_ channel, each tagged: m_tuser[0] first byte of a frame, m_tuser[1]
// header byte, m_tlast last byte of a frame. On the last byte m_tdata[40:8]
// carries the full frame length; elsewhere it is zero.
// Each frame is a header of header_bytes bytes holding a 1, 2 or 4 byte
// length field, or none; then (length - header) body bytes if the length counts
// the header, else length body bytes; nothing more when that is not positive.
// m_tvalid rises in the cycle after the input transaction. One byte is taken
// per clock: the result register is reloaded in the cycle it is drained, so
// s_tready stays high as long as m_tready is high. When the receiver stalls
// the result is held and s_tready drops until it is taken.
// Registers are written through cfg_we / cfg_index / cfg_wdata while the
// stream is idle. Synchronous reset (aresetn low) restores the register
// defaults (4 byte header, 2 byte little-endian length at offset 1) and
// starts waiting for a header; no clearing pass is needed.
module length_field_frame_deframer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lfd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lfd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] stream_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,   // [7:0] out_byte, [40:8] frame_length
    output logic [1:0]                  m_tuser,   // [0] frame_first, [1] in_header
    output logic                        m_tlast    // frame_last
);

    lfd_pkg::cfg_t cfg;

    lfd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // framing state
    logic                         in_body_reg,  in_body_next;
    logic [lfd_pkg::POS_W-1:0]    hpos_reg,     hpos_next;
    logic [lfd_pkg::LEN_W-1:0]    cap_reg,      cap_next;
    logic [lfd_pkg::FLEN_W-1:0]   rem_reg,      rem_next;
    logic [lfd_pkg::FLEN_W-1:0]   flen_reg,     flen_next;

    // result register
    logic                         m_valid_reg;
    logic [7:0]                   m_byte_reg;
    logic                         m_first_reg,  m_hdr_reg,  m_last_reg;
    logic [lfd_pkg::FLEN_W-1:0]   m_flen_reg;

    logic                         o_first, o_hdr, o_last;
    logic [lfd_pkg::FLEN_W-1:0]   o_flen;

    logic                         accept;
    logic [lfd_pkg::LEN_W-1:0]    cap_base;
    logic [lfd_pkg::OCMP_W-1:0]   p_ext, off_ext, k_full;
    logic [2:0]                   sz, lane_be;
    logic [1:0]                   lane;
    logic                         field_hit;
    logic [lfd_pkg::LEN_W-1:0]    byte_shifted;
    logic [lfd_pkg::HDR_W-1:0]    p_plus1;
    logic                         hdr_end;
    logic [lfd_pkg::FLEN_W-1:0]   cap_ext, h_ext, body_len, full_len;
    logic                         has_body;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // length field byte placement
    always_comb begin
        cap_base  = (hpos_reg == '0) ? '0 : cap_reg;
        p_ext     = lfd_pkg::OCMP_W'(hpos_reg);
        off_ext   = lfd_pkg::OCMP_W'(cfg.field_ofs);
        k_full    = p_ext - off_ext;
        sz        = lfd_pkg::field_size(cfg.size_code);
        field_hit = (p_ext >= off_ext) && (k_full < lfd_pkg::OCMP_W'(sz));
        lane_be   = sz - 3'd1 - k_full[2:0];
        lane      = cfg.big_endian ? lane_be[1:0] : k_full[1:0];
        case (lane)
            2'd0:    byte_shifted = {24'd0, s_tdata};
            2'd1:    byte_shifted = {16'd0, s_tdata, 8'd0};
            2'd2:    byte_shifted = {8'd0, s_tdata, 16'd0};
            default: byte_shifted = {s_tdata, 24'd0};
        endcase
        cap_next = field_hit ? (cap_base | byte_shifted) : cap_base;
    end

    // frame length from the completed field; full - header needs no subtract
    // when the header is not counted
    always_comb begin
        p_plus1  = lfd_pkg::HDR_W'(hpos_reg) + lfd_pkg::HDR_W'(1);
        hdr_end  = p_plus1 >= cfg.hdr_len;
        cap_ext  = lfd_pkg::FLEN_W'(cap_next);
        h_ext    = lfd_pkg::FLEN_W'(cfg.hdr_len);
        if (cfg.counts_header) begin
            has_body = cap_ext > h_ext;
            body_len = cap_ext - h_ext;
            full_len = cap_ext;
        end else begin
            has_body = cap_next != '0;
            body_len = cap_ext;
            full_len = cap_ext + h_ext;
        end
    end

    // next framing state
    always_comb begin
        in_body_next = in_body_reg;
        hpos_next    = hpos_reg;
        rem_next     = rem_reg;
        flen_next    = flen_reg;
        if (in_body_reg) begin
            if (rem_reg <= lfd_pkg::FLEN_W'(1)) begin
                in_body_next = 1'b0;
                hpos_next    = '0;
                rem_next     = '0;
            end else begin
                rem_next = rem_reg - lfd_pkg::FLEN_W'(1);
            end
        end else if (hdr_end) begin
            hpos_next = '0;
            if (has_body) begin
                in_body_next = 1'b1;
                rem_next     = body_len;
                flen_next    = full_len;
            end
        end else begin
            hpos_next = lfd_pkg::POS_W'(p_plus1);
        end
    end

    // result tags
    always_comb begin
        o_first = 1'b0;
        o_hdr   = 1'b0;
        o_last  = 1'b0;
        o_flen  = '0;
        if (in_body_reg) begin
            if (rem_reg <= lfd_pkg::FLEN_W'(1)) begin
                o_last = 1'b1;
                o_flen = flen_reg;
            end
        end else begin
            o_hdr   = 1'b1;
            o_first = hpos_reg == '0;
            if (hdr_end && !has_body) begin
                o_last = 1'b1;
                o_flen = h_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg <= 1'b0;
            hpos_reg    <= '0;
            cap_reg     <= '0;
            rem_reg     <= '0;
            flen_reg    <= '0;
        end else if (accept) begin
            in_body_reg <= in_body_next;
            hpos_reg    <= hpos_next;
            rem_reg     <= rem_next;
            flen_reg    <= flen_next;
            if (!in_body_reg) begin
                cap_reg <= cap_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_byte_reg  <= s_tdata;
            m_first_reg <= o_first;
            m_hdr_reg   <= o_hdr;
            m_last_reg  <= o_last;
            m_flen_reg  <= o_flen;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_flen_reg, m_byte_reg};
    assign m_tuser  = {m_hdr_reg, m_first_reg};
    assign m_tlast  = m_last_reg;

    // body phase always has at least one byte left
    a_body_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_body_reg |-> rem_reg != '0)
        else $error("body phase with no bytes remaining");

    // the final body byte closes the frame
    a_body_close: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_body_reg && rem_reg == lfd_pkg::FLEN_W'(1)
            |=> !in_body_reg && m_tvalid && m_tlast)
        else $error("last body byte did not end the frame");

    // a first byte is always a header byte
    a_first_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("frame start outside header");

    // length reported only on the last byte
    a_len_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[40:8] == '0)
        else $error("frame length on a non-final byte");

endmodule
